// ===== hw/rtl/sqfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse quadratic form evaluator package
// Shared constants, transaction mode codes and the vector store write port type.
// ----------------------------------------------------------------------------
package sqfe_pkg;

   // Vector store geometry.
   localparam int VECTOR_LENGTH = 1024;
   localparam int ADDR_W        = $clog2(VECTOR_LENGTH);

   // Field widths.
   localparam int INDEX_W = 10;
   localparam int ELEM_W  = 16;
   localparam int COEF_W  = 32;
   localparam int ACC_W   = 48;

   // Intermediate widths: x*x, coef*x*x, the shifted term and its doubled form.
   localparam int XX_W    = 2 * ELEM_W;
   localparam int PROD_W  = COEF_W + XX_W;
   localparam int SHIFT   = 28;
   localparam int TERM_W  = PROD_W - SHIFT;
   localparam int TERM2_W = TERM_W + 1;
   localparam int SUM_W   = ACC_W + 2;

   // Transaction modes.
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENTRY  = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // Accumulator limits.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Write port of the vector store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] data;
   } vs_write_type;

endpackage

// ===== hw/rtl/sqfe_vstore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector store
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sqfe_vstore (
   input  logic                             clock,
   input  sqfe_pkg::vs_write_type           wr,
   input  logic                             rd_en,
   input  logic [sqfe_pkg::ADDR_W-1:0]      rd_addr_a,
   input  logic [sqfe_pkg::ADDR_W-1:0]      rd_addr_b,
   output logic [sqfe_pkg::ELEM_W-1:0]      rd_data_a,
   output logic [sqfe_pkg::ELEM_W-1:0]      rd_data_b
);

   logic [sqfe_pkg::ELEM_W-1:0] mem [sqfe_pkg::VECTOR_LENGTH];
   logic [sqfe_pkg::ELEM_W-1:0] rd_data_a_ff;
   logic [sqfe_pkg::ELEM_W-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Two registered read ports, updated only while rd_en is set.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hw/rtl/sparse_quadratic_form_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse quadratic form evaluator
// Accumulates x'Qx for a symmetric sparse matrix streamed one entry at a time.
// ----------------------------------------------------------------------------
// Usage: load the vector elements first (Q2.14), then stream the matrix
// entries (Q16.16), storing each off-diagonal entry only once, and close with
// a finish transaction, which returns the objective (Q32.16) and clears the
// running sum. Loads, finishes and unused mode codes leave the sequencer idle.
// A matrix entry goes through the sequencer: the accepting cycle issues both vector
// reads to the dual-read store, then come the x[row]*x[col] multiply, the
// coefficient multiply and the saturating accumulate, and the next transaction
// is taken only after the accumulate. A finish is also held off while an
// earlier result is still waiting on the result channel. The objective is the
// negated sum when box_mode is set and the sum divided by minus four,
// truncated toward zero, otherwise; saturated reports any clamp since the
// previous finish, including the clamp of the negation.
// ----------------------------------------------------------------------------
module sparse_quadratic_form_eval (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [9:0]          req_row_index,
   input  logic [9:0]          req_column_index,
   input  logic signed [15:0]  req_vector_value,
   input  logic signed [31:0]  req_coefficient,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [47:0]  rsp_objective,
   output logic                rsp_saturated
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   logic [1:0] state_ff, state_in;

   logic                                       box_mode_ff, box_mode_in;
   logic signed [sqfe_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic                                       ovf_ff, ovf_in;
   logic signed [sqfe_pkg::COEF_W-1:0]         coef_ff, coef_in;
   logic                                       offdiag_ff, offdiag_in;
   logic                                       row_ok_ff, row_ok_in;
   logic                                       col_ok_ff, col_ok_in;
   logic signed [sqfe_pkg::XX_W-1:0]           xx_ff, xx_in;
   logic signed [sqfe_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic signed [sqfe_pkg::ACC_W-1:0]          obj_ff, obj_in;
   logic                                       sat_ff, sat_in;

   logic                                       accept;
   logic                                       row_in_range;
   logic                                       col_in_range;
   sqfe_pkg::vs_write_type                     vs_wr;
   logic                                       vs_rd_en;
   logic [sqfe_pkg::ELEM_W-1:0]                rd_a;
   logic [sqfe_pkg::ELEM_W-1:0]                rd_b;
   logic signed [sqfe_pkg::ELEM_W-1:0]         x_row;
   logic signed [sqfe_pkg::ELEM_W-1:0]         x_col;
   logic signed [sqfe_pkg::TERM_W-1:0]         term;
   logic signed [sqfe_pkg::TERM2_W-1:0]        term2;
   logic signed [sqfe_pkg::SUM_W-1:0]          sum;
   logic signed [sqfe_pkg::ACC_W:0]            acc_ext;
   logic signed [sqfe_pkg::ACC_W:0]            biased;
   logic signed [sqfe_pkg::ACC_W:0]            quot;
   logic signed [sqfe_pkg::ACC_W:0]            neg_quot;

   // Handshake: busy while an entry is in flight; a finish also waits for
   // the result register to drain.
   assign req_stall = (state_ff != ST_IDLE)
                    || ((req_mode == sqfe_pkg::MODE_FINISH) && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign row_in_range = int'(req_row_index) < sqfe_pkg::VECTOR_LENGTH;
   assign col_in_range = int'(req_column_index) < sqfe_pkg::VECTOR_LENGTH;

   // Vector store access.
   always_comb begin
      vs_wr.en   = accept && (req_mode == sqfe_pkg::MODE_LOAD) && row_in_range;
      vs_wr.addr = sqfe_pkg::ADDR_W'(req_row_index);
      vs_wr.data = req_vector_value;
   end

   assign vs_rd_en = accept && (req_mode == sqfe_pkg::MODE_ENTRY);

   sqfe_vstore u_vstore (
      .clock     (clock),
      .wr        (vs_wr),
      .rd_en     (vs_rd_en),
      .rd_addr_a (sqfe_pkg::ADDR_W'(req_row_index)),
      .rd_addr_b (sqfe_pkg::ADDR_W'(req_column_index)),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Elements outside the store read as zero.
   assign x_row = row_ok_ff ? signed'(rd_a) : '0;
   assign x_col = col_ok_ff ? signed'(rd_b) : '0;

   // Floor shift of the product, doubled for off-diagonal entries.
   assign term  = sqfe_pkg::TERM_W'(prod_ff >>> sqfe_pkg::SHIFT);
   assign term2 = offdiag_ff ? (sqfe_pkg::TERM2_W'(term) <<< 1) : sqfe_pkg::TERM2_W'(term);
   assign sum   = sqfe_pkg::SUM_W'(acc_ff) + sqfe_pkg::SUM_W'(term2);

   // Divide by four truncated toward zero, then negate.
   assign acc_ext  = (sqfe_pkg::ACC_W + 1)'(acc_ff);
   assign biased   = acc_ext + (acc_ff[sqfe_pkg::ACC_W-1] ? 49'sd3 : 49'sd0);
   assign quot     = biased >>> 2;
   assign neg_quot = -quot;

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      box_mode_in  = box_mode_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      coef_in      = coef_ff;
      offdiag_in   = offdiag_ff;
      row_ok_in    = row_ok_ff;
      col_ok_in    = col_ok_ff;
      xx_in        = xx_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      obj_in       = obj_ff;
      sat_in       = sat_ff;

      if (csr_wr_en) begin
         box_mode_in = csr_wr_data;
      end

      // Result register drains when taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  sqfe_pkg::MODE_ENTRY: begin
                     coef_in    = req_coefficient;
                     offdiag_in = req_row_index != req_column_index;
                     row_ok_in  = row_in_range;
                     col_ok_in  = col_in_range;
                     state_in   = ST_MUL1;
                  end
                  sqfe_pkg::MODE_FINISH: begin
                     rsp_valid_in = 1'b1;
                     if (box_mode_ff) begin
                        if (acc_ff == sqfe_pkg::ACC_MIN) begin
                           obj_in = sqfe_pkg::ACC_MAX;
                           sat_in = 1'b1;
                        end else begin
                           obj_in = -acc_ff;
                           sat_in = ovf_ff;
                        end
                     end else begin
                        obj_in = sqfe_pkg::ACC_W'(neg_quot);
                        sat_in = ovf_ff;
                     end
                     acc_in = '0;
                     ovf_in = 1'b0;
                  end
                  default: begin
                     // Loads go straight to the store; the unused code is dropped.
                  end
               endcase
            end
         end
         ST_MUL1: begin
            xx_in    = x_row * x_col;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = sqfe_pkg::PROD_W'(coef_ff) * sqfe_pkg::PROD_W'(xx_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Saturating accumulate.
            if (sum > sqfe_pkg::SUM_W'(sqfe_pkg::ACC_MAX)) begin
               acc_in = sqfe_pkg::ACC_MAX;
               ovf_in = 1'b1;
            end else if (sum < sqfe_pkg::SUM_W'(sqfe_pkg::ACC_MIN)) begin
               acc_in = sqfe_pkg::ACC_MIN;
               ovf_in = 1'b1;
            end else begin
               acc_in = sqfe_pkg::ACC_W'(sum);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         box_mode_ff  <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_mode_ff  <= box_mode_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      coef_ff    <= coef_in;
      offdiag_ff <= offdiag_in;
      row_ok_ff  <= row_ok_in;
      col_ok_ff  <= col_ok_in;
      xx_ff      <= xx_in;
      prod_ff    <= prod_in;
      obj_ff     <= obj_in;
      sat_ff     <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_objective = obj_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== bench/sqfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse quadratic form evaluator checker
// Watches the request, result and register ports of the evaluator, keeps its
// own copy of the vector store, running sum and saturation flag, predicts the
// objective of every finish transaction and compares each returned result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sqfe_checker
   import sqfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [9:0]          req_row_index,
   input  logic [9:0]          req_column_index,
   input  logic signed [15:0]  req_vector_value,
   input  logic signed [31:0]  req_coefficient,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic signed [47:0]  rsp_objective,
   input  logic                rsp_saturated,
   output int                  pending_count,
   output int                  mismatch_count,
   output int                  results_checked
);

   // One predicted result of a finish transaction.
   typedef struct packed {
      logic signed [ACC_W-1:0] objective;
      logic                    saturated;
   } objective_type;

   objective_type           objective_q[$];
   logic signed [ELEM_W-1:0] vector_copy [0:VECTOR_LENGTH-1];
   longint                  running_sum;
   bit                      sum_clamped;
   bit                      box_setting;

   initial begin
      pending_count   = 0;
      mismatch_count  = 0;
      results_checked = 0;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Scaled product coef*x[row]*x[col], floored into Q32.16 and doubled
   // for an off-diagonal entry.
   function automatic longint entry_term(input logic [INDEX_W-1:0] row,
                                         input logic [INDEX_W-1:0] col,
                                         input logic signed [COEF_W-1:0] coef);
      logic signed [ELEM_W-1:0] x_row;
      logic signed [ELEM_W-1:0] x_col;
      logic signed [XX_W-1:0]   xx;
      logic signed [63:0]       prod;
      longint                   term;
      x_row = (int'(row) < VECTOR_LENGTH) ? vector_copy[row] : '0;
      x_col = (int'(col) < VECTOR_LENGTH) ? vector_copy[col] : '0;
      xx    = x_row * x_col;
      prod  = coef * xx;
      term  = prod >>> SHIFT;
      if (row != col) begin
         term = term * 2;
      end
      return term;
   endfunction

   // Objective emitted by a finish, given the current sum and setting.
   function automatic objective_type finish_result();
      objective_type result;
      longint        value;
      result.saturated = sum_clamped;
      if (box_setting) begin
         if (running_sum == longint'(ACC_MIN)) begin
            value            = longint'(ACC_MAX);
            result.saturated = 1'b1;
         end else begin
            value = -running_sum;
         end
      end else begin
         value = running_sum / -4;
      end
      result.objective = value[ACC_W-1:0];
      return result;
   endfunction

   // Compare returned results first, then apply the accepted request.
   always @(posedge clock) begin : monitor
      objective_type want;
      longint        sum;
      if (reset) begin
         running_sum = 0;
         sum_clamped = 1'b0;
         box_setting = 1'b0;
         objective_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (objective_q.size() == 0) begin
               report_mismatch($sformatf("result with none expected, objective %0d saturated %0b",
                                         rsp_objective, rsp_saturated));
            end else begin
               want = objective_q.pop_front();
               results_checked++;
               if (rsp_objective !== want.objective) begin
                  report_mismatch($sformatf("objective expected %0d got %0d",
                                            want.objective, rsp_objective));
               end
               if (rsp_saturated !== want.saturated) begin
                  report_mismatch($sformatf("saturated expected %0b got %0b",
                                            want.saturated, rsp_saturated));
               end
            end
         end

         if (csr_wr_en) begin
            box_setting = csr_wr_data;
         end

         if (req_valid && !req_stall) begin
            case (req_mode)
               MODE_LOAD: begin
                  if (int'(req_row_index) < VECTOR_LENGTH) begin
                     vector_copy[req_row_index] = req_vector_value;
                  end
               end
               MODE_ENTRY: begin
                  sum = running_sum + entry_term(req_row_index, req_column_index,
                                                 req_coefficient);
                  if (sum > longint'(ACC_MAX)) begin
                     sum         = longint'(ACC_MAX);
                     sum_clamped = 1'b1;
                  end else if (sum < longint'(ACC_MIN)) begin
                     sum         = longint'(ACC_MIN);
                     sum_clamped = 1'b1;
                  end
                  running_sum = sum;
               end
               MODE_FINISH: begin
                  objective_q.push_back(finish_result());
                  running_sum = 0;
                  sum_clamped = 1'b0;
               end
               default: begin
                  // The unused mode code changes nothing.
               end
            endcase
         end
      end
      pending_count <= objective_q.size();
   end

endmodule

// ===== bench/tb_sparse_quadratic_form_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse quadratic form evaluator testbench
// Loads vector elements, streams diagonal and off-diagonal matrix entries and
// finish transactions under random idle bursts on both channels, in both
// objective modes, with extreme element and coefficient values.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sparse_quadratic_form_eval;
   import sqfe_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         BLOCK_COUNT    = 8;
   localparam int         BLOCK_ITEMS    = 50;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic               csr_wr_data      = 1'b0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode         = MODE_LOAD;
   logic [9:0]         req_row_index    = '0;
   logic [9:0]         req_column_index = '0;
   logic signed [15:0] req_vector_value = '0;
   logic signed [31:0] req_coefficient  = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [47:0] rsp_objective;
   logic               rsp_saturated;

   int pending_count;
   int mismatch_count;
   int results_checked;

   bit idle_on = 1'b0;
   bit written [0:VECTOR_LENGTH-1];
   int loaded_idx[$];
   int n_loads;
   int n_entries;
   int n_finishes;
   int n_unused;
   int quiet_cycles;

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sparse_quadratic_form_eval DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_vector_value (req_vector_value),
      .req_coefficient  (req_coefficient),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_objective    (rsp_objective),
      .rsp_saturated    (rsp_saturated)
   );

   sqfe_checker sqfe_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_vector_value (req_vector_value),
      .req_coefficient  (req_coefficient),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_objective    (rsp_objective),
      .rsp_saturated    (rsp_saturated),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count),
      .results_checked  (results_checked)
   );

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles at %0t ns",
                     WATCHDOG_LIMIT, $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Result channel back-pressure in random bursts.
   initial begin : rsp_backpressure
      forever begin
         @(posedge clock);
         if (!reset && idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one request transaction and hold it until it is accepted.
   task automatic send_item(input logic [1:0] mode, input logic [INDEX_W-1:0] row,
                            input logic [INDEX_W-1:0] col,
                            input logic signed [ELEM_W-1:0] value,
                            input logic signed [COEF_W-1:0] coef);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_row_index    <= row;
      req_column_index <= col;
      req_vector_value <= value;
      req_coefficient  <= coef;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (mode)
         MODE_LOAD: begin
            n_loads++;
            if (!written[row]) begin
               written[row] = 1'b1;
               loaded_idx.push_back(int'(row));
            end
         end
         MODE_ENTRY:  n_entries++;
         MODE_FINISH: n_finishes++;
         default:     n_unused++;
      endcase
   endtask

   // Unused fields of each kind carry random values.
   task automatic send_load(input logic [INDEX_W-1:0] idx, input logic signed [ELEM_W-1:0] value);
      send_item(MODE_LOAD, idx, INDEX_W'($urandom), value, COEF_W'($urandom));
   endtask

   task automatic send_entry(input logic [INDEX_W-1:0] row, input logic [INDEX_W-1:0] col,
                             input logic signed [COEF_W-1:0] coef);
      send_item(MODE_ENTRY, row, col, ELEM_W'($urandom), coef);
   endtask

   task automatic send_finish();
      send_item(MODE_FINISH, INDEX_W'($urandom), INDEX_W'($urandom), ELEM_W'($urandom),
                COEF_W'($urandom));
   endtask

   // Wait until the block is idle, then write the objective mode register.
   task automatic write_box_mode(input logic value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return COEF_W'($urandom_range(0, 511)) - 32'sd256;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_loaded();
      return INDEX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
   endfunction

   initial begin : stimulus
      int                 sel;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part in divide-by-minus-four mode.
      write_box_mode(1'b0);
      send_load(10'd1000, 16'sh8000);
      send_load(10'd1001, 16'sh8000);
      send_load(10'd0, 16'sh7FFF);
      send_load(10'd1023, 16'sh8000);
      send_load(10'd5, 16'sd1);
      send_load(10'd6, -16'sd1);
      send_finish();
      send_entry(10'd0, 10'd0, 32'sh7FFF_FFFF);
      send_entry(10'd0, 10'd1023, 32'sh8000_0000);
      send_item(MODE_UNUSED, 10'h3FF, 10'h3FF, 16'shFFFF, 32'shFFFF_FFFF);
      send_finish();
      // Tiny negative products round toward minus infinity; odd sums truncate.
      send_entry(10'd5, 10'd6, 32'sd1);
      send_entry(10'd6, 10'd6, -32'sd1);
      send_entry(10'd5, 10'd6, 32'sd1);
      send_finish();
      send_entry(10'd5, 10'd5, 32'sh5000_0000);
      send_finish();

      // Directed part in box mode.
      write_box_mode(1'b1);
      send_entry(10'd5, 10'd5, 32'sh3000_0000);
      send_finish();
      send_entry(10'd1000, 10'd1001, 32'sh8000_0000);
      send_finish();
      send_finish();

      // Random blocks: mostly well-formed load, entry, finish streams with noise.
      for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
         write_box_mode(logic'($urandom_range(0, 1)));
         idle_on = (blk == BLOCK_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         repeat (3) send_load(INDEX_W'($urandom), rand_value());
         for (int k = 0; k < BLOCK_ITEMS - 4; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
               row = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom) : pick_loaded();
               send_load(row, rand_value());
            end else if (sel < 78) begin
               row = pick_loaded();
               col = ($urandom_range(0, 2) == 0) ? row : pick_loaded();
               send_entry(row, col, rand_coef());
            end else if (sel < 90) begin
               send_finish();
            end else begin
               send_item(MODE_UNUSED, INDEX_W'($urandom), INDEX_W'($urandom),
                         ELEM_W'($urandom), COEF_W'($urandom));
            end
         end
         send_finish();
      end

      // Drain and let the pipeline settle.
      req_valid <= 1'b0;
      idle_on = 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Summary: %0d loads, %0d matrix entries, %0d finishes, %0d unused-mode items",
               n_loads, n_entries, n_finishes, n_unused);
      $display("Summary: %0d results checked over both objective modes and extreme operands",
               results_checked);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
